FILE: sv/pplim_pkg.sv
// Package for the path point speed limit unit.
// Holds the pipeline payload type and the register indexes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pplim_pkg;

  // Register indexes on the configuration port (byte address is 4 * index).
  localparam logic [1:0] REG_REF_LEN  = 2'd0;
  localparam logic [1:0] REG_LAT_ACC  = 2'd1;
  localparam logic [1:0] REG_MIN_CURV = 2'd2;
  localparam logic [1:0] REG_LOW_SPD  = 2'd3;

  localparam int unsigned SPEED_W = 16;
  localparam int unsigned ACC_W   = 66;

  // One path point as it travels down the square root search.
  typedef struct packed {
    logic [31:0]        station;
    logic [15:0]        map_limit;
    logic               beyond;
    logic [32:0]        k;        // floored curvature magnitude
    logic [SPEED_W-1:0] v;        // speed bits settled so far
    logic [ACC_W-1:0]   p;        // v * v * k
    logic [ACC_W-1:0]   kv;       // k * v
  } pp_item_t;

endpackage
`default_nettype wire

FILE: sv/pplim_sqrt_stage.sv
// One bit of the curve-limit search: settles speed bit BIT_POS of a point.
// Depends on pplim_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pplim_sqrt_stage
  import pplim_pkg::*;
#(
  parameter int unsigned BIT_POS = 0
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        advance,
  input  wire logic [15:0] accel,
  input  wire logic        valid_in,
  input  wire pp_item_t    item_in,
  output logic             valid_out,
  output pp_item_t         item_out
);

  logic [ACC_W-1:0] trial_p;
  logic [ACC_W-1:0] bound;
  pp_item_t         item_next;

  // Trial square times k, built from the running products by shifts and adds.
  always_comb begin
    trial_p = item_in.p + (item_in.kv << (BIT_POS + 1))
            + ({{(ACC_W-33){1'b0}}, item_in.k} << (2 * BIT_POS));
    bound   = {{(ACC_W-48){1'b0}}, accel, 32'd0};
    item_next = item_in;
    if (trial_p <= bound) begin
      item_next.v  = item_in.v | (SPEED_W'(1) << BIT_POS);
      item_next.p  = trial_p;
      item_next.kv = item_in.kv + ({{(ACC_W-33){1'b0}}, item_in.k} << BIT_POS);
    end
  end

  // Stage register; the valid bit needs reset, the payload does not.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (advance) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      item_out <= item_next;
    end
  end

endmodule
`default_nettype wire

FILE: sv/path_point_speed_limit_unit.sv
// Path point speed limit unit: top level with register file and pipeline.
// Depends on pplim_pkg and pplim_sqrt_stage.
//
// Usage: one path point enters per beat on the input channel (in_valid,
// in_stall) and one result leaves per beat on the output channel (out_valid,
// out_stall). The result carries the path station, the speed limit and the
// beyond-end flag. Registers must be written through the APB-style port only
// while no point is in flight; the block itself does not enforce this.
// Pipeline: a front stage for the curvature floor and end check, the 16
// bit-per-stage square root search stages, and a final clamp stage.
// Throughput is one point per cycle while the output is not stalled.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_stall goes high in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none
module path_point_speed_limit_unit
  import pplim_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] path_station,
  input  wire logic [31:0] line_station,
  input  wire logic signed [31:0] curvature,
  input  wire logic [15:0] map_speed_limit,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_station,
  output logic [15:0]      speed_limit,
  output logic             beyond_end
);

  localparam int unsigned NSTAGE = SPEED_W;

  logic [31:0] reference_length;
  logic [15:0] lateral_accel_limit;
  logic [30:0] min_curvature;
  logic [15:0] lowest_speed;

  logic        advance;
  logic [32:0] mag;
  logic [32:0] k_floor;
  pp_item_t    front_next;

  logic        stg_valid [NSTAGE+1];
  pp_item_t    stg_item  [NSTAGE+1];
  logic [15:0] clamp_next;

  // Configuration registers.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_length    <= 32'hFFFF_FFFF;
      lateral_accel_limit <= 16'd512;
      min_curvature       <= 31'd168;
      lowest_speed        <= 16'd640;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_REF_LEN:  reference_length    <= pwdata;
        REG_LAT_ACC:  lateral_accel_limit <= pwdata[15:0];
        REG_MIN_CURV: min_curvature       <= pwdata[30:0];
        REG_LOW_SPD:  lowest_speed        <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_REF_LEN:  prdata = reference_length;
      REG_LAT_ACC:  prdata = {16'd0, lateral_accel_limit};
      REG_MIN_CURV: prdata = {1'b0, min_curvature};
      REG_LOW_SPD:  prdata = {16'd0, lowest_speed};
      default:      prdata = 32'd0;
    endcase
  end

  // The pipeline moves as one unless a result is held at the output.
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  // Front stage: curvature magnitude, floor and end-of-line check.
  always_comb begin
    mag = curvature[31] ? (33'd0 - {curvature[31], curvature})
                        : {1'b0, curvature};
    k_floor = (mag > {2'b00, min_curvature}) ? mag : {2'b00, min_curvature};
    front_next.station   = path_station;
    front_next.map_limit = map_speed_limit;
    front_next.beyond    = line_station > reference_length;
    front_next.k         = k_floor;
    front_next.v         = '0;
    front_next.p         = '0;
    front_next.kv        = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid[0] <= 1'b0;
    end else if (advance) begin
      stg_valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stg_item[0] <= front_next;
    end
  end

  // Square root search, most significant speed bit first.
  for (genvar g = 0; g < NSTAGE; g++) begin : g_search
    pplim_sqrt_stage #(
      .BIT_POS (NSTAGE - 1 - g)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .accel     (lateral_accel_limit),
      .valid_in  (stg_valid[g]),
      .item_in   (stg_item[g]),
      .valid_out (stg_valid[g+1]),
      .item_out  (stg_item[g+1])
    );
  end

  // Final clamp between the map limit and the lowest speed; zero beyond the end.
  always_comb begin
    clamp_next = (stg_item[NSTAGE].map_limit < stg_item[NSTAGE].v)
               ? stg_item[NSTAGE].map_limit : stg_item[NSTAGE].v;
    if (clamp_next < lowest_speed) begin
      clamp_next = lowest_speed;
    end
    if (stg_item[NSTAGE].beyond) begin
      clamp_next = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= stg_valid[NSTAGE];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_station <= stg_item[NSTAGE].station;
      speed_limit <= clamp_next;
      beyond_end  <= stg_item[NSTAGE].beyond;
    end
  end

endmodule
`default_nettype wire

FILE: sv/pplim_checker.sv
// Port-level checks for the path point speed limit unit, bound to the top.
// Depends on path_point_speed_limit_unit.
`timescale 1ns / 1ps
`default_nettype none
module pplim_port_checks (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_station,
  input wire logic [15:0] speed_limit,
  input wire logic        beyond_end
);

  // No result straight after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown after reset");

  // A point past the end carries a zero speed.
  a_beyond_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && beyond_end) |-> (speed_limit == 16'd0))
    else $error("beyond-end point has nonzero speed");

  // A held result back-pressures the input in the same cycle.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> in_stall)
    else $error("input accepted while output held");

  // A stalled result stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_station)
                                  && $stable(speed_limit)))
    else $error("stalled result changed");

endmodule

bind path_point_speed_limit_unit pplim_port_checks u_pplim_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_station (out_station),
  .speed_limit (speed_limit),
  .beyond_end  (beyond_end)
);
`default_nettype wire
